@@ rtl/core/shs_pkg.sv @@
`default_nettype none

package shs_pkg;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_ABSORB  = 2'd0,
        ACT_FINAL   = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LOCKED   = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Controls for the shared round unit
    typedef struct packed {
        logic init_iv;  // reload chaining words with the initial values
        logic load;     // working vars <= chaining words
        logic step;     // one compression round
        logic accum;    // chaining words += working vars
    } t_rnd_ctrl;

    localparam int unsigned ROUNDS     = 64;
    localparam int unsigned BLOCK_BITS = 512;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LEN_POS    = 6'd56;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sha256_stream_hasher.sv @@
`default_nettype none

// Streaming SHA-256 engine. Each input item carries an action: absorb one
// message byte, finalize, or restart. Every 64th byte completes a block and
// the engine is then busy with 64 rounds on the single shared round unit,
// one round per cycle, and then with folding the result into the chaining
// words. A finalize shifts the 0x80 marker, zero padding and the 64-bit
// bit length into the block buffer one byte per cycle, runs one or two
// compressions, then emits the digest as eight items, word 0 (most
// significant) first, last_word set on word 7, one per cycle while the
// output is not stalled; the engine then locks.
// Absorb or finalize on a locked engine returns one item with status 1; an
// absorb at the maximum byte count, or a finalize whose bit length would not
// fit 64 bits, returns status 2. Rejections carry word_index and digest_word
// zero, last_word 1, and change no state. Restart reloads the initial hash
// values, clears the counters and unlocks, without a result; action code 3
// is taken and ignored. Input is taken only when the sequencer is idle and
// the output register is free or draining; results leave through a
// registered output stage.
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [1:0]  o_status,
    output logic      [2:0]  o_word_index,
    output logic      [31:0] o_digest_word,
    output logic             o_last_word
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PAD  = 6'b000010,   // zero padding bytes
        S_LEN  = 6'b000100,   // bit length bytes, MSB first
        S_COMP = 6'b001000,   // 64 rounds
        S_SUM  = 6'b010000,   // chaining update
        S_EMIT = 6'b100000    // digest words out
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_count, n_count;   // byte count; holds bit length once finalizing
    logic        r_locked, n_locked;
    logic        r_fin, n_fin;       // finalize in progress
    logic        r_len_done, n_len_done;
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_idx, n_idx;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [2:0]  r_word_index;
    logic [31:0] r_digest;
    logic        r_last;

    logic        w_out_free;
    logic        w_in_take;
    logic [5:0]  w_fill_inc;
    logic        w_shift;
    logic [7:0]  w_shift_val;
    logic        w_sched;
    t_rnd_ctrl   w_ctrl;
    logic [31:0] w_w;
    logic [31:0] w_h_word;

    logic        w_out_load;
    t_status     w_out_status;
    logic [2:0]  w_out_idx;
    logic [31:0] w_out_word;
    logic        w_out_last;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_fill_inc = r_fill + 6'd1;

    shs_msg_buf u_buf (
        .i_clk        (i_clk),
        .i_shift_byte (w_shift),
        .i_byte       (w_shift_val),
        .i_sched      (w_sched),
        .o_w          (w_w)
    );

    shs_round u_rnd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_k      (K_TABLE[r_rnd]),
        .i_w      (w_w),
        .i_sel    (r_idx),
        .o_h_word (w_h_word)
    );

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_count      = r_count;
        n_locked     = r_locked;
        n_fin        = r_fin;
        n_len_done   = r_len_done;
        n_rnd        = r_rnd;
        n_idx        = r_idx;
        w_shift      = 1'b0;
        w_shift_val  = '0;
        w_sched      = 1'b0;
        w_ctrl       = '0;
        w_out_load   = 1'b0;
        w_out_status = ST_OK;
        w_out_idx    = '0;
        w_out_word   = '0;
        w_out_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    unique case (i_action)
                        ACT_ABSORB: begin
                            if (r_locked) begin
                                w_out_load   = 1'b1;
                                w_out_status = ST_LOCKED;
                                w_out_last   = 1'b1;
                            end else if (&r_count) begin
                                w_out_load   = 1'b1;
                                w_out_status = ST_OVERFLOW;
                                w_out_last   = 1'b1;
                            end else begin
                                n_count     = r_count + 64'd1;
                                w_shift     = 1'b1;
                                w_shift_val = i_data_byte;
                                n_fill      = w_fill_inc;
                                if (w_fill_inc == '0) begin
                                    n_state     = S_COMP;
                                    n_rnd       = '0;
                                    w_ctrl.load = 1'b1;
                                end
                            end
                        end
                        ACT_FINAL: begin
                            if (r_locked) begin
                                w_out_load   = 1'b1;
                                w_out_status = ST_LOCKED;
                                w_out_last   = 1'b1;
                            end else if (|r_count[63:61]) begin
                                w_out_load   = 1'b1;
                                w_out_status = ST_OVERFLOW;
                                w_out_last   = 1'b1;
                            end else begin
                                n_count     = {r_count[60:0], 3'b000};
                                n_fin       = 1'b1;
                                n_len_done  = 1'b0;
                                w_shift     = 1'b1;
                                w_shift_val = PAD_BYTE;
                                n_fill      = w_fill_inc;
                                if (w_fill_inc == '0) begin
                                    n_state     = S_COMP;
                                    n_rnd       = '0;
                                    w_ctrl.load = 1'b1;
                                end else if (w_fill_inc == LEN_POS) begin
                                    n_state = S_LEN;
                                end else begin
                                    n_state = S_PAD;
                                end
                            end
                        end
                        ACT_RESTART: begin
                            w_ctrl.init_iv = 1'b1;
                            n_fill         = '0;
                            n_count        = '0;
                            n_locked       = 1'b0;
                            n_fin          = 1'b0;
                            n_len_done     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAD: begin
                w_shift = 1'b1;
                n_fill  = w_fill_inc;
                if (w_fill_inc == '0) begin
                    n_state     = S_COMP;
                    n_rnd       = '0;
                    w_ctrl.load = 1'b1;
                end else if (w_fill_inc == LEN_POS) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                w_shift     = 1'b1;
                w_shift_val = r_count[63:56];
                n_count     = {r_count[55:0], 8'h00};
                n_fill      = w_fill_inc;
                if (w_fill_inc == '0) begin
                    n_state     = S_COMP;
                    n_rnd       = '0;
                    n_len_done  = 1'b1;
                    w_ctrl.load = 1'b1;
                end
            end
            S_COMP: begin
                w_ctrl.step = 1'b1;
                w_sched     = 1'b1;
                n_rnd       = r_rnd + 6'd1;
                if (&r_rnd) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                w_ctrl.accum = 1'b1;
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_len_done) begin
                    n_state = S_EMIT;
                    n_idx   = '0;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_idx  = r_idx;
                    w_out_word = w_h_word;
                    w_out_last = &r_idx;
                    n_idx      = r_idx + 3'd1;
                    if (&r_idx) begin
                        n_state    = S_IDLE;
                        n_locked   = 1'b1;
                        n_fin      = 1'b0;
                        n_len_done = 1'b0;
                        n_fill     = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_count    <= '0;
            r_locked   <= 1'b0;
            r_fin      <= 1'b0;
            r_len_done <= 1'b0;
            r_rnd      <= '0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_count    <= n_count;
            r_locked   <= n_locked;
            r_fin      <= n_fin;
            r_len_done <= n_len_done;
            r_rnd      <= n_rnd;
            r_idx      <= n_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_status     <= w_out_status;
            r_word_index <= w_out_idx;
            r_digest     <= w_out_word;
            r_last       <= w_out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_word_index  = r_word_index;
    assign o_digest_word = r_digest;
    assign o_last_word   = r_last;

`ifndef SYNTH
    // 64 rounds always end in the chaining update
    a_comp_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && r_rnd == 6'd63) |=> (r_state == S_SUM))
        else $error("compression did not end in chaining update");

    // length bytes only go into the last eight byte slots
    a_len_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (r_fill >= LEN_POS))
        else $error("length byte outside final slots");

    // digest items mark last exactly on word 7
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_OK) |-> (r_last == (r_word_index == 3'd7)))
        else $error("last marker on wrong digest word");

    // sending word 7 locks the engine
    a_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && r_idx == 3'd7) |=> (r_locked && r_state == S_IDLE))
        else $error("engine not locked after digest");
`endif

endmodule

`default_nettype wire

@@ rtl/core/shs_msg_buf.sv @@
`default_nettype none

// Block buffer: bytes shift in at the low end; during compression the same
// register acts as the 16-word message schedule window (oldest word on top).
module shs_msg_buf
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_shift_byte,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_sched,
    output logic      [31:0] o_w
);

    logic [BLOCK_BITS-1:0] r_buf;
    logic [BLOCK_BITS-1:0] n_buf;
    logic [31:0]           w_new;

    // W[t+16] = W[t] + s0(W[t+1]) + W[t+9] + s1(W[t+14])
    assign w_new = r_buf[511:480] + small_sigma0(r_buf[479:448]) +
                   r_buf[223:192] + small_sigma1(r_buf[63:32]);

    assign o_w = r_buf[511:480];

    always_comb begin
        n_buf = r_buf;
        if (i_shift_byte) begin
            n_buf = {r_buf[BLOCK_BITS-9:0], i_byte};
        end else if (i_sched) begin
            n_buf = {r_buf[BLOCK_BITS-33:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

endmodule

`default_nettype wire

@@ rtl/core/shs_round.sv @@
`default_nettype none

// Chaining words plus the a..h working registers; one round per step.
module shs_round
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_rnd_ctrl   i_ctrl,
    input  wire logic [31:0] i_k,
    input  wire logic [31:0] i_w,
    input  wire logic [2:0]  i_sel,
    output logic      [31:0] o_h_word
);

    logic [31:0] r_h [8];
    logic [31:0] r_s [8];
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    assign w_ch  = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
    assign w_maj = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);
    assign w_t1  = r_s[7] + big_sigma1(r_s[4]) + w_ch + i_k + i_w;
    assign w_t2  = big_sigma0(r_s[0]) + w_maj;

    assign o_h_word = r_h[i_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= H_INIT;
        end else if (i_ctrl.init_iv) begin
            r_h <= H_INIT;
        end else if (i_ctrl.accum) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_s[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_s <= r_h;
        end else if (i_ctrl.step) begin
            r_s[7] <= r_s[6];
            r_s[6] <= r_s[5];
            r_s[5] <= r_s[4];
            r_s[4] <= r_s[3] + w_t1;
            r_s[3] <= r_s[2];
            r_s[2] <= r_s[1];
            r_s[1] <= r_s[0];
            r_s[0] <= w_t1 + w_t2;
        end
    end

endmodule

`default_nettype wire

@@ dv/sha256_digest_checker.sv @@
`default_nettype none

// Watches both channels of the SHA-256 engine, keeps its own model of the
// hash state and compares every result item with the oldest expected one.
module sha256_digest_checker
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_status,
    input  wire logic [2:0]  i_word_index,
    input  wire logic [31:0] i_digest_word,
    input  wire logic        i_last_word,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct {
        t_status     status;
        logic [2:0]  idx;
        logic [31:0] word;
        logic        last;
    } digest_res_t;

    localparam logic [31:0] RND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [63:0] MAX_BYTES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_FIN_BYTES = 64'h1FFF_FFFF_FFFF_FFFF;

    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] byte_cnt;
    logic        locked;

    digest_res_t words_due [$];
    digest_res_t due;
    bit          bad;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void run_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[i-7]
                 + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            chain[i] = IV_WORDS[i];
        for (int i = 0; i < 64; i++)
            blk[i] = '0;
        fill     = '0;
        byte_cnt = '0;
        locked   = 1'b0;
    endfunction

    function automatic void push_reject(input t_status code);
        words_due.push_back('{code, 3'd0, 32'd0, 1'b1});
    endfunction

    function automatic void hash_item(input logic [1:0] act, input logic [7:0] b);
        logic [63:0] bits;
        int          pos;
        case (act)
            ACT_ABSORB: begin
                if (locked)
                    push_reject(ST_LOCKED);
                else if (byte_cnt == MAX_BYTES)
                    push_reject(ST_OVERFLOW);
                else begin
                    byte_cnt = byte_cnt + 1;
                    blk[fill] = b;
                    fill = fill + 1'b1;
                    if (fill == 0)
                        run_block();
                end
            end
            ACT_FINAL: begin
                if (locked)
                    push_reject(ST_LOCKED);
                else if (byte_cnt > MAX_FIN_BYTES)
                    push_reject(ST_OVERFLOW);
                else begin
                    bits = byte_cnt << 3;
                    blk[fill] = 8'h80;
                    pos = int'(fill) + 1;
                    // no room for the length field: pad out and spill a block
                    if (pos > 56) begin
                        for (int i = pos; i < 64; i++)
                            blk[i] = '0;
                        run_block();
                        pos = 0;
                    end
                    for (int i = pos; i < 56; i++)
                        blk[i] = '0;
                    for (int i = 0; i < 8; i++)
                        blk[63-i] = bits[8*i +: 8];
                    run_block();
                    for (int i = 0; i < 8; i++)
                        words_due.push_back('{ST_OK, 3'(i), chain[i], 1'(i == 7)});
                    for (int i = 0; i < 64; i++)
                        blk[i] = '0;
                    fill   = '0;
                    locked = 1'b1;
                end
            end
            ACT_RESTART: restart_hash();
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_hash();
        end else begin
            if (i_in_valid && !i_in_stall)
                hash_item(i_action, i_data_byte);
            if (i_out_valid && !i_out_stall) begin
                if (words_due.size() == 0) begin
                    $error("unexpected result: status %0d index %0d word %h last %0d",
                           i_status, i_word_index, i_digest_word, i_last_word);
                    o_fail_count++;
                end else begin
                    due = words_due.pop_front();
                    bad = 1'b0;
                    if (i_status !== due.status) begin
                        $error("status: expected %0d, actual %0d", due.status, i_status);
                        bad = 1'b1;
                    end
                    if (i_word_index !== due.idx) begin
                        $error("word_index: expected %0d, actual %0d",
                               due.idx, i_word_index);
                        bad = 1'b1;
                    end
                    if (i_digest_word !== due.word) begin
                        $error("digest_word: expected %h, actual %h",
                               due.word, i_digest_word);
                        bad = 1'b1;
                    end
                    if (i_last_word !== due.last) begin
                        $error("last_word: expected %0d, actual %0d",
                               due.last, i_last_word);
                        bad = 1'b1;
                    end
                    if (bad)
                        o_fail_count++;
                end
            end
        end
        o_pending = words_due.size();
    end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
    import shs_pkg::*;

    // Action code 3 is not a defined action; the engine must swallow it.
    localparam logic [1:0] ACT_NOP = 2'd3;

    // Receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;

    localparam int HOLD_CYCLES  = 400;  // long output hold-off for back-pressure
    localparam int DRAIN_CYCLES = 200;  // idle time after the last expected result is in

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last_word;

    int fail_count;
    int pending;

    // Stimulus bookkeeping
    int sent_items;     // items accepted, not counting ignored action codes
    int sent_finals;
    int messages;
    int burst_left;
    bit gaps_on;
    int stall_mode;
    bit hold_req;

    sha256_stream_hasher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (action),
        .i_data_byte   (data_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_word_index  (word_index),
        .o_digest_word (digest_word),
        .o_last_word   (last_word)
    );

    sha256_digest_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_action      (action),
        .i_data_byte   (data_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_word_index  (word_index),
        .i_digest_word (digest_word),
        .i_last_word   (last_word),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the engine hangs somewhere.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: stalls on its own pattern. A hold request from the stimulus
    // side makes it refuse every result for a hold-off counted here from HOLD_CYCLES.
    initial begin
        int phase;
        phase     = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req  = 1'b0;
                out_stall = 1'b0;
            end else begin
                phase = (phase + 1) % 7;
                case (stall_mode)
                    STALL_RANDOM:   out_stall = ($urandom_range(0, 99) < 35);
                    STALL_PERIODIC: out_stall = (phase < 3);
                    default:        out_stall = 1'b0;
                endcase
            end
        end
    end

    // Offers one item and returns once it is accepted. Inputs move at the
    // falling edge; valid stays up between back-to-back items of a burst.
    task automatic put_item(input logic [1:0] act, input logic [7:0] b);
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid  = 1'b1;
        action    = act;
        data_byte = b;
        do @(posedge i_clk); while (in_stall);
        if (act != ACT_NOP)
            sent_items++;
        if (act == ACT_FINAL)
            sent_finals++;
    endtask

    // Message length: mostly short ones and ones whose padding lands near the
    // block end (one- vs two-block finalize), some of medium length, a few that span blocks.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 12);
        else if (r < 85)
            return $urandom_range(53, 65);
        else if (r < 97)
            return $urandom_range(13, 52);
        else
            return $urandom_range(120, 140);
    endfunction

    // One message: restart, bytes, finalize, plus a little noise. Sometimes
    // broken: restart skipped, aborted midway, or left unfinished.
    task automatic send_message(input int len, input bit press);
        int n_tail;
        if ($urandom_range(0, 19) != 0)
            put_item(ACT_RESTART, 8'($urandom));
        for (int i = 0; i < len; i++) begin
            put_item(ACT_ABSORB, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 3)
                put_item(ACT_NOP, 8'($urandom));
            if ($urandom_range(0, 199) < 3)
                put_item(ACT_RESTART, 8'($urandom));
        end
        if (press)
            hold_req = 1'b1;
        if (press || $urandom_range(0, 9) != 0)
            put_item(ACT_FINAL, 8'($urandom));
        // trailing items: on a locked engine each bounces with one result
        n_tail = press ? 6 : $urandom_range(0, 2);
        for (int i = 0; i < n_tail; i++)
            put_item($urandom_range(0, 1) ? ACT_FINAL : ACT_ABSORB, 8'($urandom));
        messages++;
    endtask

    initial begin
        int rnd_base;
        int fin_base;
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_ABSORB;
        data_byte   = 8'h00;
        sent_items  = 0;
        sent_finals = 0;
        messages    = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        stall_mode  = STALL_RANDOM;
        hold_req    = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty message straight out of reset, then both lock
        // rejections, byte extremes, an ignored code mid-message, restart on
        // a fresh engine and a restart that aborts a message.
        put_item(ACT_FINAL,   8'h00);
        put_item(ACT_FINAL,   8'h00);
        put_item(ACT_ABSORB,  8'hFF);
        put_item(ACT_RESTART, 8'h00);
        put_item(ACT_ABSORB,  8'h00);
        put_item(ACT_ABSORB,  8'hFF);
        put_item(ACT_ABSORB,  8'hA5);
        put_item(ACT_NOP,     8'h5A);
        put_item(ACT_ABSORB,  8'h5A);
        put_item(ACT_FINAL,   8'hFF);
        put_item(ACT_NOP,     8'hFF);
        put_item(ACT_RESTART, 8'hFF);
        put_item(ACT_RESTART, 8'h00);
        put_item(ACT_ABSORB,  8'h61);
        put_item(ACT_ABSORB,  8'h62);
        put_item(ACT_RESTART, 8'h00);
        put_item(ACT_ABSORB,  8'h80);
        put_item(ACT_FINAL,   8'h00);
        put_item(ACT_ABSORB,  8'h01);

        // Random messages. The first runs with no idling on either side; the
        // second carries the long output hold-off around its finalize.
        rnd_base = sent_items;
        fin_base = sent_finals;
        while (sent_items - rnd_base < 190 || sent_finals - fin_base < 6) begin
            if (messages == 0) begin
                gaps_on    = 1'b0;
                stall_mode = STALL_NONE;
            end else begin
                gaps_on    = ($urandom_range(0, 3) != 0);
                stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            end
            send_message(pick_len(), messages == 1);
        end

        @(negedge i_clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items in %0d messages with %0d finalize items,",
                 sent_items, messages, sent_finals);
        $display("including lock rejections, aborted messages and output back-pressure.");
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
